[rtl/ieft_pkg.sv]
package ieft_pkg;

  // Event types
  localparam logic [15:0] EV_SYN = 16'd0;
  localparam logic [15:0] EV_KEY = 16'd1;
  localparam logic [15:0] EV_REL = 16'd2;
  localparam logic [15:0] EV_ABS = 16'd3;

  // Event codes
  localparam logic [15:0] CODE_AXIS_X    = 16'h0000;
  localparam logic [15:0] CODE_AXIS_Y    = 16'h0001;
  localparam logic [15:0] CODE_MT_X      = 16'h0035;
  localparam logic [15:0] CODE_MT_Y      = 16'h0036;
  localparam logic [15:0] CODE_TRACK     = 16'h0039;
  localparam logic [15:0] CODE_BTN_BASE  = 16'h0110;
  localparam logic [15:0] CODE_BTN_LAST  = 16'h0117;
  localparam logic [15:0] CODE_TOUCH     = 16'h014A;

  // Key value that marks autorepeat
  localparam logic [31:0] KEY_REPEAT = 32'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_ABS_X_MIN = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ABS_X_MAX = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ABS_Y_MIN = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ABS_Y_MAX = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MT_X_MIN  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MT_X_MAX  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MT_Y_MIN  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MT_Y_MAX  = 4'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCALE,
    ST_EMIT
  } ieft_state_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL,
    SC_DIV,
    SC_DONE
  } ieft_sc_state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] value;
    logic [31:0] lo;
    logic [31:0] hi;
  } ieft_scale_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } ieft_scale_rsp_t;

endpackage

[rtl/input_event_frame_tracker_core.sv]
// A beat is accepted in idle and latched, then passes the look state, the scale wait for
// scaled absolute axis beats, which is set by the bit-serial divider, and the emit state.
// Only one beat is in flight at a time; the input is held off while a beat is in flight,
// not while a result waits for pickup.
// Reset (rst, synchronous, active high) clears the key map valid bits, all tracked state,
// the configuration registers and both handshakes at once; no clearing pass is needed.
module input_event_frame_tracker_core
  import ieft_pkg::*;
#(
  parameter int unsigned KEY_COUNT = 256,
  parameter int unsigned ABS_RANGE = 32767
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]          cfg_wdata,
  // input events
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [63:0]          s_tdata,   // ev_type[15:0], ev_code[31:16], ev_value[63:32]
  // results
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // edge_key[7:0], edge_down[8], edge_x[40:9], edge_y[72:41], pointer_x[104:73],
  // pointer_y[136:105], button_mask[144:137], contact_x[159:145], contact_y[174:160],
  // contact_pressed[175]
  output logic [175:0]         m_tdata,
  output logic [1:0]           m_tuser    // edge_valid[0], edge_is_pointer[1]
);

  localparam int unsigned KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  ieft_state_t state, state_next;

  // configuration registers
  logic [31:0] abs_x_min, abs_x_max, abs_y_min, abs_y_max;
  logic [31:0] mt_x_min, mt_x_max, mt_y_min, mt_y_max;

  // latched event
  logic [15:0]   type_r, code_r;
  logic [31:0]   val_r;
  logic [KW-1:0] key_addr;

  // key-down map: one-bit memory plus per-entry valid bits cleared by reset
  logic          key_mem [KEY_COUNT];
  logic [KEY_COUNT-1:0] key_vld;
  logic          mem_q, vld_q;

  // tracked state
  logic [31:0] mouse_x, mouse_y, touch_x, touch_y;
  logic [7:0]  buttons;
  logic        touch_held, left_at, touch_at;

  // edge of the beat in flight
  logic        e_valid, e_ptr, e_down;
  logic [7:0]  e_key;
  logic [31:0] e_x, e_y;

  // control
  logic in_beat, key_hit, btn_hit, is_scale, key_d, key_old, key_we, sc_start, out_load;
  logic sync_now, sync_was, sync_touch;

  ieft_scale_req_t sc_req;
  ieft_scale_rsp_t sc_rsp;

  assign in_beat    = s_tvalid && s_tready;
  assign key_hit    = (type_r == EV_KEY) && (code_r < 16'(KEY_COUNT));
  assign btn_hit    = (type_r == EV_KEY) && (code_r inside {[CODE_BTN_BASE:CODE_BTN_LAST]});
  assign is_scale   = (type_r == EV_ABS) &&
                      (code_r inside {CODE_AXIS_X, CODE_AXIS_Y, CODE_MT_X, CODE_MT_Y});
  assign key_d      = (val_r != 32'd0);
  assign key_old    = vld_q && mem_q;
  assign sync_now   = buttons[0] || touch_held;
  assign sync_was   = left_at || touch_at;
  assign sync_touch = touch_held || touch_at;

  // Write config registers; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      abs_x_min <= '0;
      abs_x_max <= '0;
      abs_y_min <= '0;
      abs_y_max <= '0;
      mt_x_min  <= '0;
      mt_x_max  <= '0;
      mt_y_min  <= '0;
      mt_y_max  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ABS_X_MIN: abs_x_min <= cfg_wdata;
        REG_ABS_X_MAX: abs_x_max <= cfg_wdata;
        REG_ABS_Y_MIN: abs_y_min <= cfg_wdata;
        REG_ABS_Y_MAX: abs_y_max <= cfg_wdata;
        REG_MT_X_MIN:  mt_x_min  <= cfg_wdata;
        REG_MT_X_MAX:  mt_x_max  <= cfg_wdata;
        REG_MT_Y_MIN:  mt_y_min  <= cfg_wdata;
        REG_MT_Y_MAX:  mt_y_max  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pick the axis limits by the latched code.
  always_comb begin
    sc_req.start = sc_start;
    sc_req.value = val_r;
    case (code_r)
      CODE_AXIS_X: begin sc_req.lo = abs_x_min; sc_req.hi = abs_x_max; end
      CODE_AXIS_Y: begin sc_req.lo = abs_y_min; sc_req.hi = abs_y_max; end
      CODE_MT_X:   begin sc_req.lo = mt_x_min;  sc_req.hi = mt_x_max;  end
      default:     begin sc_req.lo = mt_y_min;  sc_req.hi = mt_y_max;  end
    endcase
  end

  ieft_scale #(
    .ABS_RANGE(ABS_RANGE)
  ) u_scale (
    .clk(clk),
    .rst(rst),
    .req(sc_req),
    .rsp(sc_rsp)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_beat) state_next = ST_LOOK;
      ST_LOOK:  state_next = is_scale ? ST_SCALE : ST_EMIT;
      ST_SCALE: if (sc_rsp.done) state_next = ST_EMIT;
      ST_EMIT:  if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_tready = (state == ST_IDLE);
    sc_start = (state == ST_LOOK) && is_scale;
    key_we   = (state == ST_LOOK) && key_hit;
    out_load = (state == ST_EMIT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Key map memory: read on acceptance, write back in the look cycle. Only one beat is
  // in flight, so a read never overlaps a pending write of the same entry.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      mem_q <= key_mem[s_tdata[16 +: KW]];
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_addr] <= key_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_vld <= '0;
    end else if (key_we) begin
      key_vld[key_addr] <= 1'b1;
    end
  end

  // Latch the event payload on acceptance.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      type_r   <= s_tdata[15:0];
      code_r   <= s_tdata[31:16];
      val_r    <= s_tdata[63:32];
      key_addr <= s_tdata[16 +: KW];
      vld_q    <= key_vld[s_tdata[16 +: KW]];
    end
  end

  // Tracked state and the edge of the beat in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      mouse_x    <= '0;
      mouse_y    <= '0;
      touch_x    <= '0;
      touch_y    <= '0;
      buttons    <= '0;
      touch_held <= 1'b0;
      left_at    <= 1'b0;
      touch_at   <= 1'b0;
    end else begin
      case (state)
        ST_LOOK: begin
          e_valid <= 1'b0;
          e_ptr   <= 1'b0;
          e_down  <= 1'b0;
          e_key   <= '0;
          e_x     <= '0;
          e_y     <= '0;
          case (type_r)
            EV_KEY: begin
              if (key_hit) begin
                // autorepeat updates the map but emits nothing
                if ((val_r != KEY_REPEAT) && (key_old != key_d)) begin
                  e_valid <= 1'b1;
                  e_key   <= code_r[7:0];
                  e_down  <= key_d;
                end
              end else if (btn_hit) begin
                buttons[code_r[2:0]] <= key_d;
              end else if (code_r == CODE_TOUCH) begin
                touch_held <= key_d;
              end
            end
            EV_REL: begin
              if (code_r == CODE_AXIS_X) begin
                mouse_x <= mouse_x + val_r;
              end else if (code_r == CODE_AXIS_Y) begin
                mouse_y <= mouse_y + val_r;
              end
            end
            EV_ABS: begin
              if (code_r == CODE_TRACK) begin
                touch_held <= !val_r[31];
              end
            end
            EV_SYN: begin
              // primary press changed since the last frame: emit a pointer edge
              if (sync_now != sync_was) begin
                e_valid <= 1'b1;
                e_ptr   <= 1'b1;
                e_down  <= sync_now;
                e_x     <= sync_touch ? touch_x : mouse_x;
                e_y     <= sync_touch ? touch_y : mouse_y;
              end
              left_at  <= buttons[0];
              touch_at <= touch_held;
            end
            default: ;
          endcase
        end
        ST_SCALE: begin
          if (sc_rsp.done) begin
            case (code_r)
              CODE_AXIS_X: begin
                mouse_x <= sc_rsp.result;
                touch_x <= sc_rsp.result;
              end
              CODE_AXIS_Y: begin
                mouse_y <= sc_rsp.result;
                touch_y <= sc_rsp.result;
              end
              CODE_MT_X: touch_x <= sc_rsp.result;
              default:   touch_y <= sc_rsp.result;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: hold a result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= {e_ptr, e_valid};
      m_tdata <= {touch_held, touch_y[14:0], touch_x[14:0], buttons, mouse_y, mouse_x,
                  e_y, e_x, e_down, e_key};
    end
  end

  // The scaler answers only while the core waits for it.
  a_scale_done: assert property (@(posedge clk) disable iff (rst)
    sc_rsp.done |-> (state == ST_SCALE))
    else $error("scaler finished outside the scale wait");

  // An accepted beat always goes to the look cycle next.
  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> (state == ST_LOOK))
    else $error("accepted beat did not advance to look");

  // A pointer flag never travels without a valid edge.
  a_ptr_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> m_tuser[0])
    else $error("pointer edge flagged without edge_valid");

  // No edge means empty edge fields.
  a_no_edge: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[72:0] == 73'd0))
    else $error("edge fields set on a beat without an edge");

endmodule

[rtl/ieft_scale.sv]
module ieft_scale
  import ieft_pkg::*;
#(
  parameter int unsigned ABS_RANGE = 32767
) (
  input  logic            clk,
  input  logic            rst,
  input  ieft_scale_req_t req,
  output ieft_scale_rsp_t rsp
);

  localparam int unsigned AW = $clog2(ABS_RANGE + 1);
  localparam int unsigned PW = 32 + AW;
  localparam int unsigned CW = $clog2(PW + 1);

  ieft_sc_state_t state, state_next;

  logic [32:0]   diff_w, span_w;
  logic [31:0]   diff_r, span_r;
  logic          zero_r;
  logic [PW-1:0] prod, quot;
  logic [31:0]   rem;
  logic [CW-1:0] cnt;
  logic [32:0]   shifted;
  logic          ge;

  assign diff_w  = {req.value[31], req.value} - {req.lo[31], req.lo};
  assign span_w  = {req.hi[31], req.hi} - {req.lo[31], req.lo};
  assign shifted = {rem, prod[PW-1]};
  assign ge      = shifted >= {1'b0, span_r};

  always_comb begin
    state_next = state;
    case (state)
      SC_IDLE: if (req.start) state_next = SC_MUL;
      SC_MUL:  state_next = zero_r ? SC_DONE : SC_DIV;
      SC_DIV:  if (cnt == CW'(1)) state_next = SC_DONE;
      SC_DONE: state_next = SC_IDLE;
      default: state_next = SC_IDLE;
    endcase
  end

  always_comb begin
    rsp.done   = (state == SC_DONE);
    rsp.result = (quot > PW'(ABS_RANGE)) ? 32'(ABS_RANGE) : quot[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      SC_IDLE: begin
        if (req.start) begin
          diff_r <= diff_w[31:0];
          span_r <= span_w[31:0];
          // span or offset not positive: result is zero
          zero_r <= span_w[32] || (span_w == 33'd0) || diff_w[32] || (diff_w == 33'd0);
        end
      end
      SC_MUL: begin
        prod <= PW'(diff_r) * PW'(ABS_RANGE);
        rem  <= '0;
        quot <= '0;
        cnt  <= CW'(PW);
      end
      SC_DIV: begin
        // restoring division, one quotient bit per cycle
        rem  <= ge ? 32'(shifted - {1'b0, span_r}) : shifted[31:0];
        quot <= {quot[PW-2:0], ge};
        prod <= prod << 1;
        cnt  <= cnt - CW'(1);
      end
      default: ;
    endcase
  end

endmodule
